// ===== hdl/msd_pkg.sv =====
`default_nettype none
package msd_pkg;
	localparam int MaxSamples = 1024;
	localparam int AddrW = $clog2(MaxSamples);
	localparam int CntW = $clog2(MaxSamples + 1);
	localparam int SumW = 16 + CntW;
	localparam int SqW = 32 + CntW;
	localparam int DevW = SqW + CntW + 1;
	localparam int QW = 4;

	// one queued job for the back end
	typedef struct packed {
		logic [CntW-1:0] n;
		logic            ovf;
	} job_t;
endpackage
`default_nettype wire

// ===== hdl/mean_and_std_deviation.sv =====
`default_nettype none
// channel | ports                                       | taken when
// input   | sample, last                                | start && !busy
// result  | mean_q8, std_dev_q8, sample_total, overflow | done, one cycle
// words that are not last are taken back to back, one buffer write each
// a last word queues a job and raises busy until its result has gone out
// back end: queue register, buffer walk, prep, two serial divides
// (one quotient bit per step), square root, output register, then done
// busy falls as done ends; reset clears the sample count, drop flag and queue
// the receiver cannot stall: done marks the result for one cycle
module mean_and_std_deviation (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire logic signed [15:0]  sample,
	input  wire                      last,
	output logic                     done,
	output logic signed [23:0]       mean_q8,
	output logic [23:0]              std_dev_q8,
	output logic [10:0]              sample_total,
	output logic                     overflow
);
	logic take, wr_en, push, pop;
	logic [msd_pkg::AddrW-1:0] wr_addr;
	logic signed [15:0] wr_data;
	msd_pkg::job_t job_in;
	// set pending from its last word until its result
	logic pend_q;
	// one-entry job queue between front and back
	logic jv_q;
	msd_pkg::job_t jq_q;

	// buffer is shared: new words wait while a set is pending or being walked
	assign busy = pend_q;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			jv_q   <= 1'b0;
			jq_q   <= '0;
		end else begin
			if (push) pend_q <= 1'b1;
			else if (done) pend_q <= 1'b0;
			if (push) begin
				jv_q <= 1'b1;
				jq_q <= job_in;
			end else if (pop) begin
				jv_q <= 1'b0;
			end
		end
	end

	msd_front u_front (.clk, .arst_n, .take, .sample, .last, .wr_en, .wr_addr,
		.wr_data, .job_push(push), .job(job_in));

	msd_back u_back (.clk, .arst_n, .wr_en, .wr_addr, .wr_data,
		.job_valid(jv_q), .job(jq_q), .job_pop(pop), .done,
		.mean_q8, .std_dev_q8, .sample_total, .overflow);
endmodule
`default_nettype wire

// ===== hdl/msd_front.sv =====
`default_nettype none
module msd_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        take,
	input  wire logic signed [15:0]    sample,
	input  wire                        last,
	output logic                       wr_en,
	output logic [msd_pkg::AddrW-1:0]  wr_addr,
	output logic signed [15:0]         wr_data,
	output logic                       job_push,
	output msd_pkg::job_t              job
);
	logic [msd_pkg::CntW-1:0] count_q;
	logic                     drop_q;
	logic                     full;

	assign full     = count_q == msd_pkg::CntW'(msd_pkg::MaxSamples);
	assign wr_en    = take && !full;
	assign wr_addr  = count_q[msd_pkg::AddrW-1:0];
	assign wr_data  = sample;
	assign job_push = take && last;
	assign job.n    = full ? count_q : count_q + 1'b1;
	assign job.ovf  = drop_q || full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (take) begin
			if (last) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end else if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/msd_back.sv =====
`default_nettype none
module msd_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  wire [msd_pkg::AddrW-1:0]         wr_addr,
	input  wire logic signed [15:0]          wr_data,
	input  wire                              job_valid,
	input  wire msd_pkg::job_t               job,
	output logic                             job_pop,
	output logic                             done,
	output logic signed [23:0]               mean_q8,
	output logic [23:0]                      std_dev_q8,
	output logic [10:0]                      sample_total,
	output logic                             overflow
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_SCAN = 7'b0000010, S_PROD = 7'b0000100,
		S_DIVM = 7'b0001000, S_DIVV = 7'b0010000, S_SQRT = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	localparam int DW = msd_pkg::DevW + 16;
	localparam int NW = msd_pkg::CntW;
	localparam int MW = 2 * NW;

	logic signed [15:0] mem [msd_pkg::MaxSamples];
	logic signed [15:0] rd_s1;
	logic [msd_pkg::CntW:0] idx_q;
	logic rdv_s1;
	state_t st_q;
	msd_pkg::job_t job_q;
	logic signed [msd_pkg::SumW-1:0] sum_q;
	logic [msd_pkg::SqW-1:0] sq_q;
	logic [DW-1:0] num_q, rem_q;
	logic [7:0] k_q;
	logic [msd_pkg::SumW+7:0] absn;
	logic neg_q;
	logic [MW-1:0] m_q;
	logic [DW:0] trial;
	logic [49:0] x_q, res_q, bit_q;
	logic signed [23:0] mean_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1 <= mem[idx_q[msd_pkg::AddrW-1:0]];
	end

	assign job_pop = st_q == S_IDLE && job_valid;
	assign absn = sum_q[msd_pkg::SumW-1] ? {-sum_q, 8'd0} : {sum_q, 8'd0};
	assign trial = {rem_q, num_q[DW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			rdv_s1 <= 1'b0;
		end else begin
			done <= 1'b0;
			rdv_s1 <= 1'b0;
			unique case (st_q)
				S_IDLE: if (job_valid) begin
					job_q <= job; idx_q <= '0; sum_q <= '0; sq_q <= '0;
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					// one buffer read per cycle, sum and sum of squares
					if (idx_q < {1'b0, job_q.n}) begin
						idx_q <= idx_q + 1'b1; rdv_s1 <= 1'b1;
					end else if (!rdv_s1) st_q <= S_PROD;
					if (rdv_s1) begin
						sum_q <= sum_q + msd_pkg::SumW'(rd_s1);
						sq_q <= sq_q + msd_pkg::SqW'($unsigned(32'(rd_s1 * rd_s1)));
					end
				end
				S_PROD: begin
					neg_q <= sum_q[msd_pkg::SumW-1];
					num_q <= sum_q[msd_pkg::SumW-1] ? DW'(absn) + DW'(job_q.n) - 1'b1
						: DW'(absn);
					m_q <= MW'(job_q.n);
					rem_q <= '0; k_q <= '0;
					st_q <= S_DIVM;
				end
				S_DIVM, S_DIVV: begin
					// restoring divider, one quotient bit per cycle
					if (trial >= (DW+1)'(m_q)) begin
						rem_q <= DW'(trial - (DW+1)'(m_q)); num_q <= {num_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= DW'(trial); num_q <= {num_q[DW-2:0], 1'b0};
					end
					k_q <= k_q + 1'b1;
					if (k_q == 8'(DW-1)) begin
						k_q <= '0;
						if (st_q == S_DIVM) begin
							mean_q <= neg_q ? -24'({num_q[DW-2:0], trial >= (DW+1)'(m_q)})
								: 24'({num_q[DW-2:0], trial >= (DW+1)'(m_q)});
							num_q <= DW'({DW'(job_q.n) * DW'(sq_q)
								- DW'(absn >> 8) * DW'(absn >> 8), 16'd0});
							m_q <= MW'(job_q.n) * MW'(job_q.n);
							rem_q <= '0;
							st_q <= S_DIVV;
						end else begin
							x_q <= 50'({num_q[DW-2:0], trial >= (DW+1)'(m_q)});
							res_q <= '0; bit_q <= 50'd1 << 48;
							st_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (bit_q == '0) st_q <= S_OUT;
					else begin
						if (x_q >= res_q + bit_q) begin
							x_q <= x_q - (res_q + bit_q); res_q <= (res_q >> 1) + bit_q;
						end else res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
					end
				end
				S_OUT: begin
					done <= 1'b1; mean_q8 <= mean_q; std_dev_q8 <= res_q[23:0];
					sample_total <= 11'(job_q.n); overflow <= job_q.ovf;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
